[hdl/kpc_pkg.sv]
// ----------------------------------------------------------------------------
// kpc_pkg
// Types, register codes and constants of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

	localparam int NUM_KEYS = 8;
	localparam int KEY_W    = 3;
	localparam int TIME_W   = 32;
	localparam int DEB_W    = 16;
	localparam int UNITS_W  = 8;
	localparam int THR_W    = 15;
	localparam int UNIT_MS  = 100;
	localparam int KEY_SLOTS = 2 ** KEY_W;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [DEB_W-1:0]   DEBOUNCE_RST = DEB_W'(20);
	localparam logic [UNITS_W-1:0] LONG_RST     = UNITS_W'(10);
	localparam logic [UNITS_W-1:0] HOLD_RST     = UNITS_W'(20);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_DOWN    = 3'd1,
		ST_LONG    = 3'd2,
		ST_HOLD    = 3'd3,
		ST_DOWN_UP = 3'd4,
		ST_LONG_UP = 3'd5,
		ST_HOLD_UP = 3'd6
	} key_state_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_HOLD     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              level;
		logic [TIME_W-1:0] change_time;
		key_state_t        state;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [DEB_W-1:0] debounce;
		logic [THR_W-1:0] long_thr;
		logic [THR_W-1:0] hold_thr;
	} thr_t;

endpackage

[hdl/kpc_ifs.sv]
// ----------------------------------------------------------------------------
// kpc_ifs
// Request channels of the key press classifier: poll in, result out.
// ----------------------------------------------------------------------------
interface kpc_poll_if import kpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  key_index;
	logic              raw_level;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, key_index, raw_level, now_ms, input ready);
	modport sink   (input valid, key_index, raw_level, now_ms, output ready);
endinterface

interface kpc_res_if import kpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_id;
	logic [2:0]       key_state;
	logic             state_changed;

	modport source (output valid, key_id, key_state, state_changed, input ready);
	modport sink   (input valid, key_id, key_state, state_changed, output ready);
endinterface

[hdl/kpc_ram.sv]
// ----------------------------------------------------------------------------
// kpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/kpc_update.sv]
// ----------------------------------------------------------------------------
// kpc_update
// Next-entry logic for one key: debounce timer and press state machine.
// ----------------------------------------------------------------------------
module kpc_update import kpc_pkg::*; (
	input  entry_t            cur,
	input  logic              raw_level,
	input  logic [TIME_W-1:0] now_ms,
	input  thr_t              thr,
	output entry_t            nxt,
	output logic              changed
);

	logic [TIME_W-1:0] ct;
	logic [TIME_W-1:0] stable;
	logic              settled;
	key_state_t        st;

	always_comb begin
		ct      = (raw_level != cur.level) ? now_ms : cur.change_time;
		stable  = now_ms - ct;
		settled = stable >= TIME_W'(thr.debounce);
		st      = cur.state;

		if (settled) begin
			if (raw_level) begin
				unique case (cur.state)
					ST_IDLE: st = ST_DOWN;
					ST_DOWN: if (stable > TIME_W'(thr.long_thr)) begin
						st = ST_LONG;
					end
					ST_LONG: if (stable > TIME_W'(thr.hold_thr)) begin
						st = ST_HOLD;
					end
					default: st = cur.state;
				endcase
			end else begin
				unique case (cur.state)
					ST_DOWN:    st = ST_DOWN_UP;
					ST_LONG:    st = ST_LONG_UP;
					ST_HOLD:    st = ST_HOLD_UP;
					ST_DOWN_UP,
					ST_LONG_UP,
					ST_HOLD_UP: st = ST_IDLE;
					default:    st = cur.state;
				endcase
			end
		end

		changed = st != cur.state;

		nxt.level       = raw_level;
		nxt.change_time = (changed && st == ST_HOLD) ? now_ms : ct;
		nxt.state       = st;
	end

endmodule

[hdl/key_press_classifier.sv]
// ----------------------------------------------------------------------------
// key_press_classifier
// Per-key debounce with down / long / hold press classification.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  poll     in   valid/ready   key_index, raw_level, now_ms
//  result   out  valid/ready   key_id, key_state, state_changed
//  apb      in   psel/penable  paddr, pwdata, pwrite -> prdata, pready
//
//  One poll per cycle unless the result stalls; a poll passes stage 1 and the
//  result register. Key entries live in one RAM: read at accept, updated and
//  written back as stage 1 advances, last write forwarded on a key match.
//  Reset clears config to defaults and the per-key valid bits (no RAM sweep).
//  A stalled result holds the update stage, which holds poll.ready low.
// ----------------------------------------------------------------------------
module key_press_classifier import kpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	kpc_poll_if.sink           poll,
	kpc_res_if.source          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// configuration
	logic [UNITS_W-1:0] long_units_q;
	logic [UNITS_W-1:0] hold_units_q;
	thr_t               thr_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.debounce <= DEBOUNCE_RST;
			long_units_q   <= LONG_RST;
			hold_units_q   <= HOLD_RST;
			thr_q.long_thr <= THR_W'(LONG_RST) * THR_W'(UNIT_MS);
			thr_q.hold_thr <= THR_W'(HOLD_RST) * THR_W'(UNIT_MS);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DEBOUNCE: thr_q.debounce <= pwdata[DEB_W-1:0];
				REG_LONG: begin
					long_units_q   <= pwdata[UNITS_W-1:0];
					thr_q.long_thr <= THR_W'(pwdata[UNITS_W-1:0]) * THR_W'(UNIT_MS);
				end
				REG_HOLD: begin
					hold_units_q   <= pwdata[UNITS_W-1:0];
					thr_q.hold_thr <= THR_W'(pwdata[UNITS_W-1:0]) * THR_W'(UNIT_MS);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_DEBOUNCE: prdata = PDATA_W'(thr_q.debounce);
			REG_LONG:     prdata = PDATA_W'(long_units_q);
			REG_HOLD:     prdata = PDATA_W'(hold_units_q);
			default:      prdata = '0;
		endcase
	end

	// pipeline control
	logic out_v_q;
	logic out_free;
	logic s1_v_q;
	logic s1_adv;
	logic accept;

	assign out_free   = !out_v_q || result.ready;
	assign s1_adv     = s1_v_q && out_free;
	assign poll.ready = !s1_v_q || out_free;
	assign accept     = poll.valid && poll.ready;

	// stage 1 request
	logic [KEY_W-1:0]  key_s1;
	logic              lvl_s1;
	logic [TIME_W-1:0] now_s1;
	logic              vld_s1;

	// entry store
	logic [KEY_SLOTS-1:0] vld_q;
	logic                 ram_we;
	logic [ENTRY_W-1:0]   ram_rdata;
	logic                 wr_v_q;
	logic [KEY_W-1:0]     wr_key_q;
	entry_t               wr_data_q;
	entry_t               cur;
	entry_t               nxt;
	logic                 changed;
	logic                 key_ok;
	logic                 fwd;

	kpc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(KEY_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(key_s1),
		.wdata(nxt),
		.re   (accept),
		.raddr(poll.key_index),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (poll.ready) begin
			s1_v_q <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= poll.key_index;
			lvl_s1 <= poll.raw_level;
			now_s1 <= poll.now_ms;
			vld_s1 <= vld_q[poll.key_index];
		end
	end

	assign key_ok = {1'b0, key_s1} < (KEY_W + 1)'(NUM_KEYS);
	assign fwd    = wr_v_q && (wr_key_q == key_s1);
	assign ram_we = s1_adv && key_ok;

	always_comb begin
		if (fwd) begin
			cur = wr_data_q;
		end else if (vld_s1) begin
			cur = entry_t'(ram_rdata);
		end else begin
			cur = entry_t'('0);
		end
	end

	kpc_update u_update (
		.cur      (cur),
		.raw_level(lvl_s1),
		.now_ms   (now_s1),
		.thr      (thr_q),
		.nxt      (nxt),
		.changed  (changed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			wr_v_q <= 1'b0;
		end else if (ram_we) begin
			vld_q[key_s1] <= 1'b1;
			wr_v_q        <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_key_q  <= key_s1;
			wr_data_q <= nxt;
		end
	end

	// result register
	logic [KEY_W-1:0] key_id_q;
	key_state_t       state_q;
	logic             changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			key_id_q  <= key_s1;
			state_q   <= key_ok ? nxt.state : ST_IDLE;
			changed_q <= key_ok && changed;
		end
	end

	assign result.valid         = out_v_q;
	assign result.key_id        = key_id_q;
	assign result.key_state     = state_q;
	assign result.state_changed = changed_q;

	// checks
	a_stall_blocks_poll: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && out_v_q && !result.ready |-> !poll.ready)
		else $error("poll accepted while update stage stalled");

	a_write_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> s1_v_q && out_free)
		else $error("entry write without advancing request");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_v_q)
		else $error("accepted poll lost before update stage");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_v_q)
		else $error("advanced request lost before result register");

endmodule

[test/tb_key_press_classifier.sv]
// ----------------------------------------------------------------------------
// tb_key_press_classifier
// Drives key polls through the classifier under random bursts and result
// stalls, predicts debounce / down / long / hold transitions per key and
// checks every result in order, across several register settings.
// ----------------------------------------------------------------------------
module tb_key_press_classifier import kpc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 7;
	localparam int PHASE_POLLS  = 200;

	typedef struct packed {
		logic [KEY_W-1:0] key_id;
		key_state_t       key_state;
		logic             state_changed;
	} poll_outcome_t;

	class press_tracker;
		logic [DEB_W-1:0]   debounce;
		logic [UNITS_W-1:0] long_units;
		logic [UNITS_W-1:0] hold_units;
		logic               key_level [NUM_KEYS];
		logic [TIME_W-1:0]  change_time [NUM_KEYS];
		key_state_t         press_state [NUM_KEYS];
		poll_outcome_t      pending [$];
		int                 errors;
		int                 checked;
		int                 changes;
		bit [6:0]           seen_states;

		function new();
			debounce   = DEBOUNCE_RST;
			long_units = LONG_RST;
			hold_units = HOLD_RST;
			foreach (key_level[i]) begin
				key_level[i]   = 1'b0;
				change_time[i] = '0;
				press_state[i] = ST_IDLE;
			end
			errors      = 0;
			checked     = 0;
			changes     = 0;
			seen_states = '0;
		endfunction

		function void set_reg(reg_idx_t r, logic [PDATA_W-1:0] v);
			case (r)
				REG_DEBOUNCE: debounce   = v[DEB_W-1:0];
				REG_LONG:     long_units = v[UNITS_W-1:0];
				REG_HOLD:     hold_units = v[UNITS_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_poll(logic [KEY_W-1:0] k, logic lvl, logic [TIME_W-1:0] t);
			poll_outcome_t     o;
			key_state_t        old_st;
			key_state_t        new_st;
			logic [TIME_W-1:0] stable;
			logic [TIME_W-1:0] long_ms;
			logic [TIME_W-1:0] hold_ms;
			o.key_id        = k;
			o.key_state     = ST_IDLE;
			o.state_changed = 1'b0;
			if (int'(k) < NUM_KEYS) begin
				long_ms = TIME_W'(long_units) * TIME_W'(UNIT_MS);
				hold_ms = TIME_W'(hold_units) * TIME_W'(UNIT_MS);
				if (lvl != key_level[k]) begin
					key_level[k]   = lvl;
					change_time[k] = t;
				end
				stable = t - change_time[k];
				old_st = press_state[k];
				new_st = old_st;
				if (stable >= TIME_W'(debounce)) begin
					if (lvl) begin
						case (old_st)
							ST_IDLE: new_st = ST_DOWN;
							ST_DOWN: if (stable > long_ms) new_st = ST_LONG;
							ST_LONG: if (stable > hold_ms) new_st = ST_HOLD;
							default: ;
						endcase
					end else begin
						case (old_st)
							ST_DOWN: new_st = ST_DOWN_UP;
							ST_LONG: new_st = ST_LONG_UP;
							ST_HOLD: new_st = ST_HOLD_UP;
							ST_DOWN_UP, ST_LONG_UP, ST_HOLD_UP: new_st = ST_IDLE;
							default: ;
						endcase
					end
					press_state[k] = new_st;
					// entering hold restarts the timer
					if (new_st != old_st && new_st == ST_HOLD)
						change_time[k] = t;
				end
				o.key_state     = new_st;
				o.state_changed = (new_st != old_st);
				if (new_st != old_st) begin
					changes++;
					seen_states[new_st] = 1'b1;
				end
			end
			pending.push_back(o);
		endfunction

		function void check_result(logic [KEY_W-1:0] id, logic [2:0] st, logic chg);
			poll_outcome_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result key_id %0d key_state %0d state_changed %0b",
					$time, id, st, chg);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (id !== e.key_id) begin
				$display("%0t: key_id mismatch, expected %0d, actual %0d", $time, e.key_id, id);
				errors++;
			end
			if (st !== e.key_state) begin
				$display("%0t: key_state mismatch (key %0d), expected %0d, actual %0d",
					$time, e.key_id, e.key_state, st);
				errors++;
			end
			if (chg !== e.state_changed) begin
				$display("%0t: state_changed mismatch (key %0d), expected %0b, actual %0b",
					$time, e.key_id, e.state_changed, chg);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	kpc_poll_if poll_if ();
	kpc_res_if  res_if ();

	key_press_classifier DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll    (poll_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	press_tracker      tr;
	int                cycles;
	int                burst_left;
	int                rdy_left;
	logic              rdy_hold;
	int                polls_sent;
	int                settings_used;
	logic              plan_lvl [NUM_KEYS];
	int                plan_left [NUM_KEYS];
	logic [TIME_W-1:0] key_clock [NUM_KEYS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, tr.pending.size());
			$display("FAIL key_press_classifier");
			$finish;
		end
	end

	// result side stalls in runs of random length
	always @(negedge clk) begin
		if (rdy_left == 0) begin
			rdy_hold = ($urandom_range(0, 2) != 0);
			rdy_left = rdy_hold ? $urandom_range(1, 30) : $urandom_range(1, 8);
		end
		rdy_left--;
		res_if.ready = rdy_hold;
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			tr.check_result(res_if.key_id, res_if.key_state, res_if.state_changed);
	end

	task send_poll(input logic [KEY_W-1:0] k, input logic lvl, input logic [TIME_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk);
				poll_if.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		poll_if.valid     = 1'b1;
		poll_if.key_index = k;
		poll_if.raw_level = lvl;
		poll_if.now_ms    = t;
		do @(posedge clk); while (!poll_if.ready);
		tr.note_poll(k, lvl, t);
		polls_sent++;
	endtask

	task wait_drained();
		@(negedge clk);
		poll_if.valid = 1'b0;
		while (tr.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task apb_write(input reg_idx_t r, input logic [PDATA_W-1:0] v);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'(4 * int'(r));
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		tr.set_reg(r, v);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task apply_setting(input int d, input int l, input int h);
		wait_drained();
		apb_write(REG_DEBOUNCE, PDATA_W'(d));
		apb_write(REG_LONG, PDATA_W'(l));
		apb_write(REG_HOLD, PDATA_W'(h));
		settings_used++;
	endtask

	// mostly press/release episodes per key with glitches, some pure noise
	task random_poll();
		logic [KEY_W-1:0]  k;
		logic              lvl;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] step;
		int                span;
		int                sel;
		k    = KEY_W'($urandom_range(0, NUM_KEYS - 1));
		span = int'((tr.long_units > tr.hold_units) ? tr.long_units : tr.hold_units)
			* UNIT_MS + 200;
		sel  = $urandom_range(0, 99);
		if (sel < 12) begin
			lvl = 1'($urandom_range(0, 1));
			t   = $urandom;
		end else begin
			if (plan_left[k] == 0) begin
				plan_lvl[k]  = ~plan_lvl[k];
				plan_left[k] = $urandom_range(1, 12);
			end
			plan_left[k]--;
			case ($urandom_range(0, 9))
				0, 1:    step = $urandom_range(0, 3);
				2, 3, 4: step = $urandom_range(0, int'(tr.debounce) + 8);
				5, 6, 7: step = $urandom_range(0, span / 3 + 1);
				default: step = $urandom_range(0, span + int'(tr.debounce));
			endcase
			key_clock[k] = key_clock[k] + step;
			lvl = (sel < 22) ? ~plan_lvl[k] : plan_lvl[k];
			t   = key_clock[k];
		end
		send_poll(k, lvl, t);
	endtask

	initial begin
		tr                = new();
		cycles            = 0;
		burst_left        = 0;
		rdy_left          = 0;
		rdy_hold          = 1'b0;
		polls_sent        = 0;
		settings_used     = 1;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		poll_if.valid     = 1'b0;
		poll_if.key_index = '0;
		poll_if.raw_level = 1'b0;
		poll_if.now_ms    = '0;
		res_if.ready      = 1'b0;
		foreach (plan_lvl[i]) begin
			plan_lvl[i]  = 1'b0;
			plan_left[i] = 0;
			key_clock[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset thresholds: debounce edge, strict long / hold edges, hold restart
		send_poll(3'd0, 1'b1, 32'd0);
		send_poll(3'd0, 1'b1, 32'd20);
		send_poll(3'd0, 1'b1, 32'd1000);
		send_poll(3'd0, 1'b1, 32'd1001);
		send_poll(3'd0, 1'b1, 32'd2000);
		send_poll(3'd0, 1'b1, 32'd2001);
		send_poll(3'd0, 1'b1, 32'd5000);
		send_poll(3'd0, 1'b0, 32'd5005);
		send_poll(3'd0, 1'b0, 32'd5025);
		send_poll(3'd0, 1'b0, 32'd5030);
		send_poll(3'd0, 1'b0, 32'd5040);
		// timestamp wrap, press while in an up state
		send_poll(3'd1, 1'b1, 32'hFFFF_FFF0);
		send_poll(3'd1, 1'b1, 32'h0000_0010);
		send_poll(3'd1, 1'b0, 32'h0000_0020);
		send_poll(3'd1, 1'b0, 32'h0000_0040);
		send_poll(3'd1, 1'b1, 32'h0000_0041);
		send_poll(3'd1, 1'b1, 32'h0000_0060);
		send_poll(3'd1, 1'b0, 32'h0000_0061);
		send_poll(3'd1, 1'b0, 32'h0000_0080);
		// long press released
		send_poll(3'd2, 1'b1, 32'd100);
		send_poll(3'd2, 1'b1, 32'd120);
		send_poll(3'd2, 1'b1, 32'd1200);
		send_poll(3'd2, 1'b0, 32'd1201);
		send_poll(3'd2, 1'b0, 32'd1221);
		send_poll(3'd7, 1'b1, 32'hFFFF_FFFF);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: ;
				1: apply_setting(0, 0, 0);
				2: apply_setting(65535, 255, 255);
				3: apply_setting(5, 1, 2);
				4: apply_setting(1000, 3, 0);
				5: apply_setting($urandom_range(0, 65535), $urandom_range(0, 255),
					$urandom_range(0, 255));
				default: apply_setting($urandom_range(0, 300), $urandom_range(0, 30),
					$urandom_range(0, 30));
			endcase
			foreach (key_clock[i])
				key_clock[i] = phase[0] ? (32'hFFFF_FFFF - $urandom_range(0, 40000)) : $urandom;
			for (int i = 0; i < PHASE_POLLS; i++) begin
				if (i == PHASE_POLLS / 2)
					wait_drained();
				random_poll();
			end
		end

		wait_drained();
		$display("covered %0d polls over %0d register settings, %0d results checked",
			polls_sent, settings_used, tr.checked);
		$display("%0d state changes predicted, states entered (bit per state) %07b",
			tr.changes, tr.seen_states);
		if (tr.errors == 0 && tr.pending.size() == 0) begin
			$display("PASS key_press_classifier");
		end else begin
			$display("%0d errors", tr.errors);
			$display("FAIL key_press_classifier");
		end
		$finish;
	end

endmodule
